### sv/per_axis_kalman_filter_defines.svh
// ----------------------------------------------------------------------------
// Per-axis Kalman filter assertion macros
// Shared property macros for the checker of the per-axis Kalman filter.
// ----------------------------------------------------------------------------
`ifndef PER_AXIS_KALMAN_FILTER_DEFINES_SVH
`define PER_AXIS_KALMAN_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PAKF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PAKF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/pakf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-axis Kalman filter package
// Widths, reset values and register codes shared by the filter modules.
// ----------------------------------------------------------------------------
package pakf_pkg;

    localparam int DATA_W = 32;
    localparam int K_W    = 17;
    localparam int DIMS_W = 3;
    localparam int CH_W   = 2;
    localparam int ADDR_W = 4;
    localparam int MUL_A_W = K_W + 1;
    localparam int MUL_B_W = DATA_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [K_W-1:0]    ONE_Q16    = 17'h10000;
    localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd3;
    localparam logic [DATA_W-1:0] Q_RESET    = 32'd655;
    localparam logic [DATA_W-1:0] R_RESET    = 32'd6554;
    localparam logic [DATA_W-1:0] VAR_RESET  = 32'h0001_0000;

    typedef enum logic [1:0] {
        REG_DIMS   = 2'd0,
        REG_QNOISE = 2'd1,
        REG_RNOISE = 2'd2
    } reg_idx_t;

endpackage

### sv/pakf_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-axis Kalman filter gain divider
// Restoring divider that forms the Q16.16 gain p' * 2^16 / den, one
// quotient bit per cycle, for a dividend that never exceeds the divisor.
// ----------------------------------------------------------------------------
module pakf_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [pakf_pkg::DATA_W-1:0]   dividend,
    input  logic [pakf_pkg::DATA_W-1:0]   divisor,
    output logic                          done,
    output logic [pakf_pkg::K_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(pakf_pkg::K_W + 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [STEP_W-1:0]             cnt_reg;
    logic [pakf_pkg::DATA_W:0]     rem_reg;
    logic [pakf_pkg::DATA_W-1:0]   div_reg;
    logic [pakf_pkg::K_W-1:0]      quot_reg;

    logic                          rem_ge;
    logic [pakf_pkg::DATA_W:0]     rem_sub;
    logic [pakf_pkg::DATA_W:0]     rem_keep;

    assign rem_ge   = rem_reg >= {1'b0, div_reg};
    assign rem_sub  = rem_reg - {1'b0, div_reg};
    assign rem_keep = rem_ge ? rem_sub : rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !start && (cnt_reg == STEP_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(pakf_pkg::K_W);
                rem_reg  <= {1'b0, dividend};
                div_reg  <= divisor;
                quot_reg <= '0;
            end else if (busy_reg) begin
                rem_reg  <= {rem_keep[pakf_pkg::DATA_W-1:0], 1'b0};
                quot_reg <= {quot_reg[pakf_pkg::K_W-2:0], rem_ge};
                cnt_reg  <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

### sv/per_axis_kalman_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-axis Kalman filter
// Scalar random-walk Kalman filter per axis in Q16.16, one measurement a beat.
//
//   Channel  Direction  Handshake        Payload
//   s_       in         s_valid/s_ready  s_channel, s_measurement, s_vector_count
//   m_       out        m_valid/m_ready  m_channel_out, m_estimate, m_rejected
//   APB      in         psel/penable     paddr, pwdata, prdata
//
// An accepted beat is worked through in full before the next beat can be taken;
// it waits on the gain divider, which runs 17 quotient steps. A beat whose
// denominator is zero skips the division; a rejected beat goes straight to the
// final step. One shared multiplier forms both the estimate and the variance
// products. Reset restores the registers, zeroes every estimate and sets every
// variance to 1.0. A result waiting on m_ready holds the block in its final step.
// ----------------------------------------------------------------------------
module per_axis_kalman_filter #(
    parameter int MAX_AXES = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pakf_pkg::CH_W-1:0]         s_channel,
    input  logic signed [pakf_pkg::DATA_W-1:0] s_measurement,
    input  logic [pakf_pkg::DIMS_W-1:0]       s_vector_count,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pakf_pkg::CH_W-1:0]         m_channel_out,
    output logic signed [pakf_pkg::DATA_W-1:0] m_estimate,
    output logic                              m_rejected,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pakf_pkg::ADDR_W-1:0]       paddr,
    input  logic [pakf_pkg::DATA_W-1:0]       pwdata,
    output logic [pakf_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    localparam int AXIS_W = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
    localparam int DW     = pakf_pkg::DATA_W;
    localparam int KW     = pakf_pkg::K_W;
    localparam int PW     = pakf_pkg::PROD_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRED,
        ST_DEN,
        ST_DIV,
        ST_DIFF,
        ST_MULX,
        ST_UPDX,
        ST_MULP,
        ST_UPDP,
        ST_DONE
    } state_t;

    state_t                      state_reg;
    logic [pakf_pkg::DIMS_W-1:0] dims_reg;
    logic [DW-1:0]               q_reg;
    logic [DW-1:0]               r_reg;

    logic signed [DW-1:0]        est_reg [MAX_AXES];
    logic [DW-1:0]               var_reg [MAX_AXES];

    logic [pakf_pkg::CH_W-1:0]   ch_reg;
    logic [DW-1:0]               z_reg;
    logic                        rej_reg;
    logic [DW-1:0]               pp_reg;
    logic [KW-1:0]               k_reg;
    logic [DW:0]                 d_reg;
    logic signed [PW-1:0]        prod_reg;
    logic [DW-1:0]               xn_reg;
    logic                        div_start_reg;

    logic                        m_valid_reg;
    logic [pakf_pkg::CH_W-1:0]   m_channel_reg;
    logic [DW-1:0]               m_estimate_reg;
    logic                        m_rejected_reg;

    logic [AXIS_W-1:0]           idx;
    logic [DW-1:0]               p_cur;
    logic [DW-1:0]               x_cur;
    logic [DW:0]                 sum_pq;
    logic [DW-1:0]               pp_sat;
    logic [DW:0]                 sum_den;
    logic [DW-1:0]               den_sat;
    logic [DW:0]                 diff_next;
    logic signed [pakf_pkg::MUL_A_W-1:0] mul_a;
    logic signed [pakf_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PW-1:0]        mul_p;
    logic signed [PW-1:0]        rnd_sum;
    logic [PW-17:0]              rnd_x;
    logic [DW+3:0]               xn_wide;
    logic [DW-1:0]               xn_sat;
    logic [DW-1:0]               pn;
    logic                        in_bad;
    logic                        div_done;
    logic [KW-1:0]               div_quot;
    logic                        cfg_write;

    pakf_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (pp_reg),
        .divisor  (den_sat),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign idx   = AXIS_W'(ch_reg);
    assign p_cur = var_reg[idx];
    assign x_cur = est_reg[idx];

    assign sum_pq  = {1'b0, p_cur} + {1'b0, q_reg};
    assign pp_sat  = sum_pq[DW] ? {DW{1'b1}} : sum_pq[DW-1:0];
    assign sum_den = {1'b0, pp_reg} + {1'b0, r_reg};
    assign den_sat = sum_den[DW] ? {DW{1'b1}} : sum_den[DW-1:0];

    assign diff_next = {z_reg[DW-1], z_reg} - {x_cur[DW-1], x_cur};

    always_comb begin
        case (state_reg)
            ST_MULX: begin
                mul_a = $signed({1'b0, k_reg});
                mul_b = $signed(d_reg);
            end
            default: begin
                mul_a = $signed({1'b0, pakf_pkg::ONE_Q16 - k_reg});
                mul_b = $signed({1'b0, pp_reg});
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign rnd_sum = prod_reg + PW'(32768);
    assign rnd_x   = rnd_sum[PW-1:16];
    assign xn_wide = {{4{x_cur[DW-1]}}, x_cur} + {rnd_x[PW-17], rnd_x};
    assign pn      = rnd_sum[DW+15:16];

    always_comb begin
        if (xn_wide[DW+3:DW-1] == '0 || xn_wide[DW+3:DW-1] == '1) begin
            xn_sat = xn_wide[DW-1:0];
        end else if (xn_wide[DW+3]) begin
            xn_sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            xn_sat = {1'b0, {(DW-1){1'b1}}};
        end
    end

    assign in_bad = (s_vector_count != dims_reg)
                 || ({1'b0, s_channel} >= dims_reg)
                 || (32'(s_channel) >= 32'(MAX_AXES));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            div_start_reg <= 1'b0;
            for (int i = 0; i < MAX_AXES; i++) begin
                est_reg[i] <= '0;
                var_reg[i] <= pakf_pkg::VAR_RESET;
            end
        end else begin
            div_start_reg <= (state_reg == ST_DEN) && (den_sat != '0);
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        ch_reg  <= s_channel;
                        z_reg   <= s_measurement;
                        rej_reg <= in_bad;
                        state_reg <= in_bad ? ST_DONE : ST_PRED;
                    end
                end
                ST_PRED: begin
                    pp_reg    <= pp_sat;
                    state_reg <= ST_DEN;
                end
                ST_DEN: begin
                    if (den_sat == '0) begin
                        k_reg     <= '0;
                        state_reg <= ST_DIFF;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        k_reg     <= div_quot;
                        state_reg <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    d_reg     <= diff_next;
                    state_reg <= ST_MULX;
                end
                ST_MULX: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_UPDX;
                end
                ST_UPDX: begin
                    est_reg[idx] <= xn_sat;
                    xn_reg       <= xn_sat;
                    state_reg    <= ST_MULP;
                end
                ST_MULP: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_UPDP;
                end
                ST_UPDP: begin
                    var_reg[idx] <= pn;
                    state_reg    <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_channel_reg  <= ch_reg;
                        m_estimate_reg <= rej_reg ? '0 : xn_reg;
                        m_rejected_reg <= rej_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg <= pakf_pkg::DIMS_RESET;
            q_reg    <= pakf_pkg::Q_RESET;
            r_reg    <= pakf_pkg::R_RESET;
        end else if (cfg_write) begin
            case (pakf_pkg::reg_idx_t'(paddr[3:2]))
                pakf_pkg::REG_DIMS:   dims_reg <= pwdata[pakf_pkg::DIMS_W-1:0];
                pakf_pkg::REG_QNOISE: q_reg    <= pwdata;
                pakf_pkg::REG_RNOISE: r_reg    <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (pakf_pkg::reg_idx_t'(paddr[3:2]))
            pakf_pkg::REG_DIMS:   prdata = {{(DW-pakf_pkg::DIMS_W){1'b0}}, dims_reg};
            pakf_pkg::REG_QNOISE: prdata = q_reg;
            pakf_pkg::REG_RNOISE: prdata = r_reg;
            default:              prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_channel_out = m_channel_reg;
    assign m_estimate    = m_estimate_reg;
    assign m_rejected    = m_rejected_reg;

endmodule

### sv/pakf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-axis Kalman filter checker
// Port-level assertions on the filter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "per_axis_kalman_filter_defines.svh"

module pakf_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [pakf_pkg::DATA_W-1:0] m_estimate,
    input logic                               m_rejected,
    input logic                               pready
);

    `PAKF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_estimate), "Result beat dropped or changed while stalled.")
    `PAKF_ASSERT_NEXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready,
        "Input beat accepted while another one is in work.")
    `PAKF_ASSERT_NOW(a_rej_zero, aclk, aresetn, m_valid && m_rejected, m_estimate == '0,
        "Rejected beat carries a nonzero estimate.")
    `PAKF_ASSERT_NOW(a_pready, aclk, aresetn, 1'b1, pready, "Register port stalled.")

endmodule

bind per_axis_kalman_filter pakf_checker u_pakf_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_estimate (m_estimate),
    .m_rejected (m_rejected),
    .pready     (pready)
);

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-axis Kalman filter testbench
// Drives measurement beats and APB register writes into the filter, predicts
// every estimate with a bit-exact scalar filter per axis, and compares each
// output beat field by field under random source and sink stalls.
// ----------------------------------------------------------------------------
module tb;

    localparam int AXES            = 4;
    localparam int RAND_PHASES     = 6;
    localparam int BEATS_PER_PHASE = 300;
    localparam int CYCLE_LIMIT     = 1_000_000;

    typedef enum logic {
        ROW_BEAT,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t                          kind;
        pakf_pkg::reg_idx_t                 idx;
        logic [pakf_pkg::DATA_W-1:0]        value;
        logic [pakf_pkg::CH_W-1:0]          ch;
        logic signed [pakf_pkg::DATA_W-1:0] z;
        logic [pakf_pkg::DIMS_W-1:0]        cnt;
        bit                                 typed;
        logic signed [pakf_pkg::DATA_W-1:0] want_est;
        bit                                 want_rej;
    } stim_row_t;

    typedef struct {
        logic [pakf_pkg::CH_W-1:0]          ch;
        logic signed [pakf_pkg::DATA_W-1:0] est;
        logic                               rej;
    } estimate_beat_t;

    logic                                aclk           = 1'b0;
    logic                                aresetn        = 1'b0;
    logic                                s_valid        = 1'b0;
    logic                                s_ready;
    logic [pakf_pkg::CH_W-1:0]           s_channel      = '0;
    logic signed [pakf_pkg::DATA_W-1:0]  s_measurement  = '0;
    logic [pakf_pkg::DIMS_W-1:0]         s_vector_count = '0;
    logic                                m_valid;
    logic                                m_ready        = 1'b0;
    logic [pakf_pkg::CH_W-1:0]           m_channel_out;
    logic signed [pakf_pkg::DATA_W-1:0]  m_estimate;
    logic                                m_rejected;
    logic                                psel           = 1'b0;
    logic                                penable        = 1'b0;
    logic                                pwrite         = 1'b0;
    logic [pakf_pkg::ADDR_W-1:0]         paddr          = '0;
    logic [pakf_pkg::DATA_W-1:0]         pwdata         = '0;
    logic [pakf_pkg::DATA_W-1:0]         prdata;
    logic                                pready;

    logic [pakf_pkg::DIMS_W-1:0]         cfg_dims = pakf_pkg::DIMS_RESET;
    logic [pakf_pkg::DATA_W-1:0]         cfg_q    = pakf_pkg::Q_RESET;
    logic [pakf_pkg::DATA_W-1:0]         cfg_r    = pakf_pkg::R_RESET;
    logic signed [pakf_pkg::DATA_W-1:0]  est_state [AXES];
    logic [pakf_pkg::DATA_W-1:0]         var_state [AXES];

    estimate_beat_t            expected_estimates[$];
    stim_row_t                 directed_rows[$];
    int                        src_idle_pct  = 0;
    int                        sink_idle_pct = 0;
    int                        err_cnt       = 0;
    int                        cycle_cnt     = 0;

    per_axis_kalman_filter #(
        .MAX_AXES(AXES)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_channel     (s_channel),
        .s_measurement (s_measurement),
        .s_vector_count(s_vector_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_channel_out (m_channel_out),
        .m_estimate    (m_estimate),
        .m_rejected    (m_rejected),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("** per_axis_kalman_filter: FAILED **");
            $finish;
        end
    end

    function automatic estimate_beat_t kalman_update(
            input logic [pakf_pkg::CH_W-1:0] ch,
            input logic signed [pakf_pkg::DATA_W-1:0] z,
            input logic [pakf_pkg::DIMS_W-1:0] cnt);
        estimate_beat_t                res;
        logic [pakf_pkg::DATA_W:0]     sum;
        logic [pakf_pkg::DATA_W-1:0]   p_pred;
        logic [pakf_pkg::DATA_W-1:0]   den;
        logic [63:0]                   gain;
        logic [63:0]                   p_new;
        logic signed [63:0]            x;
        logic signed [63:0]            d;
        logic signed [63:0]            prod;
        logic signed [63:0]            xn;
        res.ch  = ch;
        res.est = '0;
        res.rej = 1'b1;
        if (cnt != cfg_dims || ch >= cfg_dims || ch >= AXES) begin
            return res;
        end
        sum    = {1'b0, var_state[ch]} + {1'b0, cfg_q};
        p_pred = sum[pakf_pkg::DATA_W] ? '1 : sum[pakf_pkg::DATA_W-1:0];
        sum    = {1'b0, p_pred} + {1'b0, cfg_r};
        den    = sum[pakf_pkg::DATA_W] ? '1 : sum[pakf_pkg::DATA_W-1:0];
        if (den == 0) begin
            gain = '0;
        end else begin
            gain = ({32'b0, p_pred} << 16) / {32'b0, den};
        end
        if (gain > 64'(pakf_pkg::ONE_Q16)) begin
            gain = 64'(pakf_pkg::ONE_Q16);
        end
        x    = 64'(est_state[ch]);
        d    = z - x;
        prod = $signed(gain) * d;
        xn   = x + ((prod + 64'sd32768) >>> 16);
        if (xn > 64'sd2147483647) begin
            xn = 64'sd2147483647;
        end
        if (xn < -64'sd2147483648) begin
            xn = -64'sd2147483648;
        end
        p_new = ((64'(pakf_pkg::ONE_Q16) - gain) * {32'b0, p_pred} + 64'd32768) >> 16;
        est_state[ch] = xn[pakf_pkg::DATA_W-1:0];
        var_state[ch] = p_new[pakf_pkg::DATA_W-1:0];
        res.est = xn[pakf_pkg::DATA_W-1:0];
        res.rej = 1'b0;
        return res;
    endfunction

    always @(posedge aclk) begin : result_check
        estimate_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_estimates.size() == 0) begin
                $display("%0t: unexpected result beat, channel %0d estimate %0d rejected %0b",
                         $time, m_channel_out, m_estimate, m_rejected);
                err_cnt++;
            end else begin
                want = expected_estimates.pop_front();
                if (m_channel_out !== want.ch) begin
                    $display("%0t: channel_out mismatch, expected %0d, actual %0d",
                             $time, want.ch, m_channel_out);
                    err_cnt++;
                end
                if (m_estimate !== want.est) begin
                    $display("%0t: estimate mismatch, expected %0d, actual %0d",
                             $time, want.est, m_estimate);
                    err_cnt++;
                end
                if (m_rejected !== want.rej) begin
                    $display("%0t: rejected mismatch, expected %0b, actual %0b",
                             $time, want.rej, m_rejected);
                    err_cnt++;
                end
            end
        end
    end

    task automatic apb_write(input pakf_pkg::reg_idx_t idx,
                             input logic [pakf_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            pakf_pkg::REG_DIMS:   cfg_dims = value[pakf_pkg::DIMS_W-1:0];
            pakf_pkg::REG_QNOISE: cfg_q    = value;
            pakf_pkg::REG_RNOISE: cfg_r    = value;
            default: ;
        endcase
    endtask

    task automatic drain_estimates();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_estimates.size() != 0);
    endtask

    task automatic push_beat(input logic [pakf_pkg::CH_W-1:0] ch,
                             input logic signed [pakf_pkg::DATA_W-1:0] z,
                             input logic [pakf_pkg::DIMS_W-1:0] cnt, input bit typed,
                             input logic signed [pakf_pkg::DATA_W-1:0] want_est,
                             input bit want_rej);
        estimate_beat_t want;
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_valid        <= 1'b1;
        s_channel      <= ch;
        s_measurement  <= z;
        s_vector_count <= cnt;
        do @(posedge aclk); while (!s_ready);
        want = kalman_update(ch, z, cnt);
        if (typed) begin
            want.est = want_est;
            want.rej = want_rej;
        end
        expected_estimates.push_back(want);
    endtask

    task automatic random_beat(input int valid_pct);
        logic [pakf_pkg::CH_W-1:0]          ch;
        logic [pakf_pkg::DIMS_W-1:0]        cnt;
        logic signed [pakf_pkg::DATA_W-1:0] z;
        logic [31:0]                        rnd;
        int                                 lim;
        z = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            z = $urandom_range(0, 1048576) - 524288;
        end
        if (cfg_dims != 0 && $urandom_range(0, 99) < valid_pct) begin
            lim = (cfg_dims > AXES) ? AXES : int'(cfg_dims);
            rnd = $urandom_range(0, lim - 1);
            ch  = rnd[pakf_pkg::CH_W-1:0];
            cnt = cfg_dims;
        end else begin
            rnd = $urandom;
            ch  = rnd[pakf_pkg::CH_W-1:0];
            rnd = $urandom;
            cnt = rnd[pakf_pkg::DIMS_W-1:0];
        end
        push_beat(ch, z, cnt, 1'b0, '0, 1'b0);
    endtask

    function automatic logic [pakf_pkg::DATA_W-1:0] pick_noise();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom;
            default: return $urandom_range(0, 131072);
        endcase
    endfunction

    function automatic void add_cfg(input pakf_pkg::reg_idx_t idx,
                                    input logic [pakf_pkg::DATA_W-1:0] value);
        stim_row_t row;
        row.kind     = ROW_CFG;
        row.idx      = idx;
        row.value    = value;
        row.ch       = '0;
        row.z        = '0;
        row.cnt      = '0;
        row.typed    = 1'b0;
        row.want_est = '0;
        row.want_rej = 1'b0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_beat(input logic [pakf_pkg::CH_W-1:0] ch,
                                     input logic signed [pakf_pkg::DATA_W-1:0] z,
                                     input logic [pakf_pkg::DIMS_W-1:0] cnt, input bit typed,
                                     input logic signed [pakf_pkg::DATA_W-1:0] want_est,
                                     input bit want_rej);
        stim_row_t row;
        row.kind     = ROW_BEAT;
        row.idx      = pakf_pkg::REG_DIMS;
        row.value    = '0;
        row.ch       = ch;
        row.z        = z;
        row.cnt      = cnt;
        row.typed    = typed;
        row.want_est = want_est;
        row.want_rej = want_rej;
        directed_rows.push_back(row);
    endfunction

    initial begin
        logic signed [pakf_pkg::DATA_W-1:0] s_max;
        logic signed [pakf_pkg::DATA_W-1:0] s_min;
        s_max = 32'sh7FFF_FFFF;
        s_min = 32'sh8000_0000;
        for (int i = 0; i < AXES; i++) begin
            est_state[i] = '0;
            var_state[i] = pakf_pkg::VAR_RESET;
        end

        // Reset register values, then count and channel rejections.
        add_beat(2'd0, 32'sh0001_0000, 3'd3, 1'b0, '0, 1'b0);
        add_beat(2'd1, -32'sh0001_0000, 3'd3, 1'b0, '0, 1'b0);
        add_beat(2'd2, s_max, 3'd3, 1'b0, '0, 1'b0);
        add_beat(2'd3, 32'sd77, 3'd3, 1'b1, '0, 1'b1);
        add_beat(2'd0, 32'sd5, 3'd4, 1'b1, '0, 1'b1);
        add_beat(2'd1, 32'sd5, 3'd7, 1'b1, '0, 1'b1);
        add_beat(2'd0, 32'sd5, 3'd0, 1'b1, '0, 1'b1);
        // With no noise the gain is one, after that the denominator is zero.
        add_cfg(pakf_pkg::REG_DIMS, 32'd4);
        add_cfg(pakf_pkg::REG_QNOISE, 32'd0);
        add_cfg(pakf_pkg::REG_RNOISE, 32'd0);
        add_beat(2'd3, s_min, 3'd4, 1'b1, s_min, 1'b0);
        add_beat(2'd3, 32'sd5, 3'd4, 1'b1, s_min, 1'b0);
        add_beat(2'd0, s_max, 3'd4, 1'b1, s_max, 1'b0);
        add_beat(2'd0, -32'sd7, 3'd4, 1'b1, s_max, 1'b0);
        // Saturated sums still give a gain of one.
        add_cfg(pakf_pkg::REG_QNOISE, 32'hFFFF_FFFF);
        add_cfg(pakf_pkg::REG_RNOISE, 32'hFFFF_FFFF);
        add_beat(2'd0, s_min, 3'd4, 1'b1, s_min, 1'b0);
        add_beat(2'd3, s_max, 3'd4, 1'b1, s_max, 1'b0);
        add_beat(2'd1, 32'sh0001_8000, 3'd4, 1'b0, '0, 1'b0);
        add_cfg(pakf_pkg::REG_DIMS, 32'd0);
        add_beat(2'd0, 32'sd123, 3'd0, 1'b1, '0, 1'b1);
        add_beat(2'd3, 32'sd123, 3'd3, 1'b1, '0, 1'b1);
        // More axes configured than the block has.
        add_cfg(pakf_pkg::REG_DIMS, 32'd7);
        add_cfg(pakf_pkg::REG_QNOISE, 32'd1);
        add_beat(2'd3, 32'sh1234_5678, 3'd7, 1'b0, '0, 1'b0);
        add_beat(2'd2, -32'sd1, 3'd7, 1'b0, '0, 1'b0);
        add_beat(2'd1, 32'sd9, 3'd5, 1'b1, '0, 1'b1);
        add_beat(2'd0, 32'sd9, 3'd6, 1'b1, '0, 1'b1);
        add_cfg(pakf_pkg::REG_DIMS, 32'd1);
        add_cfg(pakf_pkg::REG_QNOISE, pakf_pkg::Q_RESET);
        add_cfg(pakf_pkg::REG_RNOISE, pakf_pkg::R_RESET);
        add_beat(2'd0, 32'sh7FFF_0000, 3'd1, 1'b0, '0, 1'b0);
        add_beat(2'd1, 32'sd3, 3'd1, 1'b1, '0, 1'b1);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct  = 29;
        sink_idle_pct = 82;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                drain_estimates();
                apb_write(directed_rows[i].idx, directed_rows[i].value);
            end else begin
                push_beat(directed_rows[i].ch, directed_rows[i].z, directed_rows[i].cnt,
                          directed_rows[i].typed, directed_rows[i].want_est,
                          directed_rows[i].want_rej);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain_estimates();
            if (ph < 2) begin
                src_idle_pct  = 29;
                sink_idle_pct = 82;
            end else if (ph < 4) begin
                src_idle_pct  = 82;
                sink_idle_pct = 29;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            if (ph == 3) begin
                apb_write(pakf_pkg::REG_DIMS, $urandom_range(5, 7));
            end else begin
                apb_write(pakf_pkg::REG_DIMS, $urandom_range(1, 4));
            end
            apb_write(pakf_pkg::REG_QNOISE, pick_noise());
            apb_write(pakf_pkg::REG_RNOISE, pick_noise());
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                if (ph == 1 && n == BEATS_PER_PHASE / 2) begin
                    drain_estimates();
                end
                random_beat(85);
            end
        end

        drain_estimates();
        repeat (40) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("** per_axis_kalman_filter: PASSED **");
        end else begin
            $display("** per_axis_kalman_filter: FAILED **");
        end
        $finish;
    end

endmodule
